// File: sv/dmx_latest_change_merge_macros.svh
// Assertion macros shared by the merge block RTL.
`ifndef DMX_LATEST_CHANGE_MERGE_MACROS_SVH
`define DMX_LATEST_CHANGE_MERGE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define DMX_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition implies consequence in the next cycle.
`define DMX_ASSERT_NXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/dmx_lcm_pkg.sv
// Types, codes and constants of the DMX latest-change merge block.
package dmx_lcm_pkg;

  parameter int unsigned TicksPerFrameDefault = 64;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [7:0] FullFrameIndex = 8'd16;
  localparam logic [7:0] SatIndex       = 8'd255;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCoolSlot   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegWarmSlot   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegBrightSlot = 8'd2;
  localparam logic [CfgIdxW-1:0] RegIdleTicks  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegOutSlots   = 8'd4;

  typedef enum logic [2:0] {
    OP_RX_A     = 3'd0,
    OP_RX_B     = 3'd1,
    OP_REMOTE   = 3'd2,
    OP_TICK     = 3'd3,
    OP_TX_READY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    LINE_NONE  = 2'd0,
    LINE_BREAK = 2'd1,
    LINE_UART  = 2'd2
  } line_e;

  typedef enum logic [1:0] {
    RELAY_NONE    = 2'd0,
    RELAY_ENGAGE  = 2'd1,
    RELAY_RELEASE = 2'd2
  } relay_e;

  typedef enum logic [1:0] {
    SRC_A      = 2'd0,
    SRC_B      = 2'd1,
    SRC_REMOTE = 2'd2
  } src_e;

  typedef struct packed {
    logic [7:0] cool_slot;
    logic [7:0] warm_slot;
    logic [7:0] bright_slot;
    logic [7:0] idle_ticks;
    logic [7:0] out_slots;
  } cfg_t;

  // Update produced by one receive input for one transaction
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] idle;
    logic       cool_we;
    logic       warm_we;
    logic       bright_we;
    relay_e     relay;
    logic       select;
  } rx_upd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    line_e      line_action;
    relay_e     relay_action;
    logic       frame_sending;
    logic       b_present;
    logic [1:0] active_source;
  } result_t;

endpackage

// File: sv/dmx_lcm_rx.sv
// Next-state logic of one receive input: byte slot capture and idle gap.
module dmx_lcm_rx (
  input  logic                 byte_i,
  input  logic                 tick_i,
  input  dmx_lcm_pkg::cfg_t    cfg_i,
  input  logic [7:0]           index_i,
  input  logic [7:0]           idle_i,
  input  logic [7:0]           cool_i,
  input  logic [7:0]           warm_i,
  input  logic [7:0]           bright_i,
  input  logic [7:0]           data_i,
  output dmx_lcm_pkg::rx_upd_t upd_o
);

  logic [7:0] idx;
  logic [7:0] idle_inc;

  always_comb begin
    upd_o           = '0;
    upd_o.index     = index_i;
    upd_o.idle      = idle_i;
    upd_o.relay     = dmx_lcm_pkg::RELAY_NONE;
    idx             = index_i;
    idle_inc        = (idle_i != 8'hff) ? idle_i + 8'd1 : idle_i;
    if (byte_i) begin
      // start code: nonzero kills the rest of the frame
      if (index_i == 8'd0) begin
        if (data_i != 8'd0) idx = dmx_lcm_pkg::SatIndex;
      end else if (index_i != dmx_lcm_pkg::SatIndex) begin
        priority if (index_i == cfg_i.cool_slot) begin
          if (data_i != cool_i) begin
            upd_o.cool_we = 1'b1;
            upd_o.select  = 1'b1;
          end
        end else if (index_i == cfg_i.warm_slot) begin
          if (data_i != warm_i) begin
            upd_o.warm_we = 1'b1;
            upd_o.select  = 1'b1;
          end
        end else if (index_i == cfg_i.bright_slot) begin
          if (data_i != bright_i) begin
            upd_o.relay     = (data_i > bright_i) ? dmx_lcm_pkg::RELAY_ENGAGE
                                                  : dmx_lcm_pkg::RELAY_RELEASE;
            upd_o.bright_we = 1'b1;
            upd_o.select    = 1'b1;
          end
        end else begin
          // not a captured slot
        end
      end
      upd_o.index = (idx != dmx_lcm_pkg::SatIndex) ? idx + 8'd1 : idx;
      upd_o.idle  = 8'd0;
    end else if (tick_i) begin
      // idle gap ends the received frame
      if (idle_inc >= cfg_i.idle_ticks) begin
        upd_o.idle  = 8'd0;
        upd_o.index = 8'd0;
      end else begin
        upd_o.idle  = idle_inc;
      end
    end
  end

endmodule

// File: sv/dmx_lcm_core.sv
// Merge state, configuration registers and output frame sequencing.
`include "dmx_latest_change_merge_macros.svh"

module dmx_lcm_core #(
  parameter int unsigned TicksPerFrame = dmx_lcm_pkg::TicksPerFrameDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dmx_lcm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                step_i,
  input  dmx_lcm_pkg::op_e                    op_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic [7:0]                          remote_cool_i,
  input  logic [7:0]                          remote_warm_i,
  output dmx_lcm_pkg::result_t                res_o
);

  localparam int unsigned PhaseW = $clog2(TicksPerFrame);
  localparam logic [PhaseW-1:0] PhaseBreak = PhaseW'(TicksPerFrame - 3);
  localparam logic [PhaseW-1:0] PhaseUart  = PhaseW'(TicksPerFrame - 2);
  localparam logic [PhaseW-1:0] PhaseLast  = PhaseW'(TicksPerFrame - 1);
  localparam logic [PhaseW-1:0] PhaseAtMax = PhaseW'(255 % TicksPerFrame);

  dmx_lcm_pkg::cfg_t cfg_q;

  logic [7:0]        index_a_q, index_a_d, idle_a_q, idle_a_d;
  logic [7:0]        index_b_q, index_b_d, idle_b_q, idle_b_d;
  logic [7:0]        cool_q [3];
  logic [7:0]        cool_d [3];
  logic [7:0]        warm_q [3];
  logic [7:0]        warm_d [3];
  logic [7:0]        bright_q [2];
  logic [7:0]        bright_d [2];
  logic [1:0]        src_q, src_d;
  logic [7:0]        out_slot_q, out_slot_d;
  logic [7:0]        tick_q, tick_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              sending_q, sending_d;
  logic              b_seen_q, b_seen_d;

  dmx_lcm_pkg::rx_upd_t upd_a, upd_b;
  logic                 tick_ev;
  logic [PhaseW-1:0]    phase_inc;
  logic [7:0]           slot_inc;
  logic [1:0]           src_rd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cool_slot   <= 8'd3;
      cfg_q.warm_slot   <= 8'd4;
      cfg_q.bright_slot <= 8'd7;
      cfg_q.idle_ticks  <= 8'd3;
      cfg_q.out_slots   <= 8'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dmx_lcm_pkg::RegCoolSlot)   cfg_q.cool_slot   <= cfg_data_i;
      if (cfg_idx_i == dmx_lcm_pkg::RegWarmSlot)   cfg_q.warm_slot   <= cfg_data_i;
      if (cfg_idx_i == dmx_lcm_pkg::RegBrightSlot) cfg_q.bright_slot <= cfg_data_i;
      if (cfg_idx_i == dmx_lcm_pkg::RegIdleTicks)  cfg_q.idle_ticks  <= cfg_data_i;
      if (cfg_idx_i == dmx_lcm_pkg::RegOutSlots)   cfg_q.out_slots   <= cfg_data_i;
    end
  end

  assign tick_ev = step_i && (op_i == dmx_lcm_pkg::OP_TICK);

  // Receive inputs A and B
  dmx_lcm_rx u_rx_a (
    .byte_i   (step_i && (op_i == dmx_lcm_pkg::OP_RX_A)),
    .tick_i   (tick_ev),
    .cfg_i    (cfg_q),
    .index_i  (index_a_q),
    .idle_i   (idle_a_q),
    .cool_i   (cool_q[0]),
    .warm_i   (warm_q[0]),
    .bright_i (bright_q[0]),
    .data_i   (rx_byte_i),
    .upd_o    (upd_a)
  );

  dmx_lcm_rx u_rx_b (
    .byte_i   (step_i && (op_i == dmx_lcm_pkg::OP_RX_B)),
    .tick_i   (tick_ev),
    .cfg_i    (cfg_q),
    .index_i  (index_b_q),
    .idle_i   (idle_b_q),
    .cool_i   (cool_q[1]),
    .warm_i   (warm_q[1]),
    .bright_i (bright_q[1]),
    .data_i   (rx_byte_i),
    .upd_o    (upd_b)
  );

  // Phase of the tick count within the output frame period
  assign phase_inc = ((tick_q == 8'hff) || (phase_q == PhaseLast)) ? '0
                                                                   : phase_q + 1'b1;
  assign slot_inc  = (out_slot_q != 8'hff) ? out_slot_q + 8'd1 : out_slot_q;
  assign src_rd    = (src_q == 2'd3) ? dmx_lcm_pkg::SRC_REMOTE : src_q;

  // Next state and result of one transaction
  always_comb begin
    index_a_d  = index_a_q;
    idle_a_d   = idle_a_q;
    index_b_d  = index_b_q;
    idle_b_d   = idle_b_q;
    cool_d     = cool_q;
    warm_d     = warm_q;
    bright_d   = bright_q;
    src_d      = src_q;
    out_slot_d = out_slot_q;
    tick_d     = tick_q;
    phase_d    = phase_q;
    sending_d  = sending_q;
    b_seen_d   = b_seen_q;
    res_o      = '0;
    res_o.line_action  = dmx_lcm_pkg::LINE_NONE;
    res_o.relay_action = dmx_lcm_pkg::RELAY_NONE;
    if (step_i) begin
      unique case (op_i)
        dmx_lcm_pkg::OP_RX_A: begin
          index_a_d = upd_a.index;
          idle_a_d  = upd_a.idle;
          if (upd_a.cool_we)   cool_d[0]   = rx_byte_i;
          if (upd_a.warm_we)   warm_d[0]   = rx_byte_i;
          if (upd_a.bright_we) bright_d[0] = rx_byte_i;
          if (upd_a.select)    src_d       = dmx_lcm_pkg::SRC_A;
          res_o.relay_action = upd_a.relay;
        end
        dmx_lcm_pkg::OP_RX_B: begin
          index_b_d = upd_b.index;
          idle_b_d  = upd_b.idle;
          if (upd_b.cool_we)   cool_d[1]   = rx_byte_i;
          if (upd_b.warm_we)   warm_d[1]   = rx_byte_i;
          if (upd_b.bright_we) bright_d[1] = rx_byte_i;
          if (upd_b.select)    src_d       = dmx_lcm_pkg::SRC_B;
          res_o.relay_action = upd_b.relay;
          // presence of B follows from full-length frames
          if (index_b_q == 8'd0) begin
            b_seen_d = 1'b0;
          end else if (index_b_q == dmx_lcm_pkg::FullFrameIndex) begin
            b_seen_d = 1'b1;
          end
        end
        dmx_lcm_pkg::OP_REMOTE: begin
          cool_d[2] = remote_cool_i;
          warm_d[2] = remote_warm_i;
          src_d     = dmx_lcm_pkg::SRC_REMOTE;
        end
        dmx_lcm_pkg::OP_TICK: begin
          index_a_d = upd_a.index;
          idle_a_d  = upd_a.idle;
          index_b_d = upd_b.index;
          idle_b_d  = upd_b.idle;
          tick_d    = tick_q + 8'd1;
          phase_d   = phase_inc;
          priority if (phase_inc == PhaseBreak) begin
            res_o.line_action = dmx_lcm_pkg::LINE_BREAK;
          end else if (phase_inc == PhaseUart) begin
            res_o.line_action = dmx_lcm_pkg::LINE_UART;
          end else if (phase_inc == PhaseLast) begin
            // start code of a new output frame
            tick_d         = 8'hff;
            phase_d        = PhaseAtMax;
            out_slot_d     = 8'd1;
            sending_d      = 1'b1;
            res_o.tx_valid = 1'b1;
          end else begin
            // mid-frame tick, line untouched
          end
        end
        dmx_lcm_pkg::OP_TX_READY: begin
          if (sending_q) begin
            if ((out_slot_q != 8'd0) && (out_slot_q <= cfg_q.out_slots)) begin
              res_o.tx_valid = 1'b1;
              if (out_slot_q == 8'd1) begin
                tick_d        = 8'd0;
                phase_d       = '0;
                res_o.tx_byte = cool_q[src_rd];
              end else if (out_slot_q == 8'd2) begin
                res_o.tx_byte = warm_q[src_rd];
              end
            end
            out_slot_d = slot_inc;
            if (slot_inc > cfg_q.out_slots) sending_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    res_o.frame_sending = sending_d;
    res_o.b_present     = b_seen_d;
    res_o.active_source = src_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_a_q  <= 8'd0;
      idle_a_q   <= 8'd0;
      index_b_q  <= 8'd0;
      idle_b_q   <= 8'd0;
      for (int k = 0; k < 3; k++) begin
        cool_q[k] <= 8'd0;
        warm_q[k] <= 8'd0;
      end
      for (int k = 0; k < 2; k++) begin
        bright_q[k] <= 8'd0;
      end
      src_q      <= dmx_lcm_pkg::SRC_A;
      out_slot_q <= 8'd0;
      tick_q     <= 8'd0;
      phase_q    <= '0;
      sending_q  <= 1'b0;
      b_seen_q   <= 1'b0;
    end else begin
      index_a_q  <= index_a_d;
      idle_a_q   <= idle_a_d;
      index_b_q  <= index_b_d;
      idle_b_q   <= idle_b_d;
      cool_q     <= cool_d;
      warm_q     <= warm_d;
      bright_q   <= bright_d;
      src_q      <= src_d;
      out_slot_q <= out_slot_d;
      tick_q     <= tick_d;
      phase_q    <= phase_d;
      sending_q  <= sending_d;
      b_seen_q   <= b_seen_d;
    end
  end

  `DMX_ASSERT_IMP(a_sending_slot, clk_i, rst_ni, sending_q, out_slot_q != 8'd0)
  `DMX_ASSERT_IMP(a_src_legal, clk_i, rst_ni, 1'b1, src_q != 2'd3)
  `DMX_ASSERT_IMP(a_phase_range, clk_i, rst_ni, 1'b1, phase_q <= PhaseLast)

endmodule

// File: sv/dmx_latest_change_merge.sv
// DMX latest-change merge: input register, merge core and result register.
//
// Usage: every input transaction on the s_axis channel is one event: a byte
// received on input A or B, a remote set of cool and warm values, a timer
// tick, or a transmitter-ready notice. Each transaction gives exactly one
// result transaction on m_axis, carrying the byte to transmit (if any), the
// break/uart line action, the relay pulse, and the frame, presence and
// active-source status after the event.
// The input register takes the transaction, and the merge logic runs between
// it and the result register. Throughput is one transaction per cycle while
// m_axis_tready stays high; the merge state is a single register set.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; s_axis_tready drops only when both are
// full. Reset clears all merge state to zero and the configuration registers
// to their defaults; the cfg channel is always ready, and the user is to write
// it only while the block is idle; the block itself does not enforce this.
module dmx_latest_change_merge #(
  parameter int unsigned TicksPerFrame = dmx_lcm_pkg::TicksPerFrameDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: operation[2:0], rx_byte[10:3], remote_cool_value[18:11],
  //        remote_warm_value[26:19], zero fill[31:27]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dmx_lcm_pkg::InDataW-1:0]     s_axis_tdata,
  // tdata: tx_valid[0], tx_byte[8:1], line_action[10:9],
  //        relay_action[12:11], frame_sending[13], b_present[14],
  //        active_source[16:15], zero fill[23:17]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dmx_lcm_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dmx_lcm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);

  `include "dmx_latest_change_merge_macros.svh"

  logic                                 in_valid_q;
  logic [dmx_lcm_pkg::InDataW-1:0]      in_data_q;
  logic                                 out_valid_q;
  dmx_lcm_pkg::result_t                 res_q;
  dmx_lcm_pkg::result_t                 res_d;
  logic                                 advance;
  logic                                 in_fire;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= s_axis_tdata;
    end
  end

  dmx_lcm_core #(
    .TicksPerFrame (TicksPerFrame)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .step_i        (advance),
    .op_i          (dmx_lcm_pkg::op_e'(in_data_q[2:0])),
    .rx_byte_i     (in_data_q[10:3]),
    .remote_cool_i (in_data_q[18:11]),
    .remote_warm_i (in_data_q[26:19]),
    .res_o         (res_d)
  );

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.active_source, res_q.b_present,
                          res_q.frame_sending, res_q.relay_action,
                          res_q.line_action, res_q.tx_byte, res_q.tx_valid};

  `DMX_ASSERT_IMP(a_stall_full, clk_i, rst_ni, !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready)
  `DMX_ASSERT_NXT(a_advance_out, clk_i, rst_ni, advance, out_valid_q)
  `DMX_ASSERT_NXT(a_take_in, clk_i, rst_ni, in_fire, in_valid_q)

endmodule
